// ===== rtl/dpbp_pkg.sv =====
// Shared types, constants and register codes for the depth pixel back-projection block.
// No dependencies; every other file of the block refers to this package by scoped names.
package dpbp_pkg;

  // Field widths fixed by the interface.
  localparam int DIM_W    = 12;   // image width / height registers
  localparam int CTR_W    = 15;   // principal point, 4 fraction bits
  localparam int RECIP_W  = 24;   // reciprocal focal length, 24 fraction bits
  localparam int DEPTH_W  = 16;
  localparam int COORD_W  = 32;
  localparam int IDX_W    = 22;
  localparam int POS_W    = 12;   // widest column or row a frame can have
  localparam int MAG_W    = 16;   // |pos*16 - center|
  localparam int PART_W   = MAG_W + RECIP_W;
  localparam int PROD_W   = PART_W + DEPTH_W;
  localparam int RND_SH   = 20;   // 28 fraction bits down to 8

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Register reset values.
  localparam logic [DIM_W-1:0]   RST_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 12'd480;
  localparam logic [CTR_W-1:0]   RST_CX     = 15'd5120;
  localparam logic [CTR_W-1:0]   RST_CY     = 15'd3840;
  localparam logic [RECIP_W-1:0] RST_RFX    = 24'd31960;
  localparam logic [RECIP_W-1:0] RST_RFY    = 24'd31960;
  localparam logic [DEPTH_W-1:0] RST_THRESH = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_CX     = 3'd2,
    REG_CY     = 3'd3,
    REG_RFX    = 3'd4,
    REG_RFY    = 3'd5,
    REG_THRESH = 3'd6
  } cfg_reg_t;

  // One selected pixel as classified by the front.
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               invalid;
    logic [IDX_W-1:0]   idx;
  } item_t;

  // Queue status seen by the front and the top level.
  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // Camera intrinsics used by the back.
  typedef struct packed {
    logic [CTR_W-1:0]   cx;
    logic [CTR_W-1:0]   cy;
    logic [RECIP_W-1:0] rfx;
    logic [RECIP_W-1:0] rfy;
  } cam_cfg_t;

endpackage

// ===== rtl/depth_pixel_back_projection.sv =====
// Top level of the depth pixel back-projection block: configuration registers and the
// front end, queue and projection pipeline. Depends on dpbp_pkg, dpbp_front, dpbp_queue, dpbp_back.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_stall    depth_value, pixel_selected
//   out_      output     out_valid / out_stall  point_x, point_y, point_z, point_invalid,
//                                               pixel_index
//   cfg_      input      cfg_write_en           cfg_index, cfg_data
//
// One pixel request is taken per clock while the queue has room; a selected pixel is
// written into the queue at the accepting edge, then passes through the registered offset
// product, depth product and rounding stages before it is presented as a point, and the
// pipeline sustains one point per clock while out_stall is low.
// Reset is synchronous and active low; it clears the raster counters, the queue and all
// stage valids, and loads the register defaults. No clearing pass is needed.
// out_stall holds the output stage; the two inner stages close up behind it, then the queue
// fills, and in_stall rises only when all four queue entries are taken.
module depth_pixel_back_projection #(
  parameter int MAX_WIDTH  = dpbp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dpbp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Pixel input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dpbp_pkg::DEPTH_W-1:0]    in_depth_value,
  input  logic                            in_pixel_selected,
  // Point output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dpbp_pkg::COORD_W-1:0]    out_point_x,
  output logic [dpbp_pkg::COORD_W-1:0]    out_point_y,
  output logic [dpbp_pkg::DEPTH_W-1:0]    out_point_z,
  output logic                            out_point_invalid,
  output logic [dpbp_pkg::IDX_W-1:0]      out_pixel_index,
  // Configuration writes
  input  logic                            cfg_write_en,
  input  logic [dpbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpbp_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [dpbp_pkg::DIM_W-1:0]   width_r, height_r;
  logic [dpbp_pkg::CTR_W-1:0]   cx_r, cy_r;
  logic [dpbp_pkg::RECIP_W-1:0] rfx_r, rfy_r;
  logic [dpbp_pkg::DEPTH_W-1:0] thresh_r;

  dpbp_pkg::cam_cfg_t cam;
  dpbp_pkg::qstat_t   q_stat;
  dpbp_pkg::item_t    q_item, head_item;
  logic q_push, q_pop, head_valid;

  // Register writes land on the field's low bits; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dpbp_pkg::RST_WIDTH;
      height_r <= dpbp_pkg::RST_HEIGHT;
      cx_r     <= dpbp_pkg::RST_CX;
      cy_r     <= dpbp_pkg::RST_CY;
      rfx_r    <= dpbp_pkg::RST_RFX;
      rfy_r    <= dpbp_pkg::RST_RFY;
      thresh_r <= dpbp_pkg::RST_THRESH;
    end else if (cfg_write_en) begin
      case (dpbp_pkg::cfg_reg_t'(cfg_index))
        dpbp_pkg::REG_WIDTH:  width_r  <= cfg_data[dpbp_pkg::DIM_W-1:0];
        dpbp_pkg::REG_HEIGHT: height_r <= cfg_data[dpbp_pkg::DIM_W-1:0];
        dpbp_pkg::REG_CX:     cx_r     <= cfg_data[dpbp_pkg::CTR_W-1:0];
        dpbp_pkg::REG_CY:     cy_r     <= cfg_data[dpbp_pkg::CTR_W-1:0];
        dpbp_pkg::REG_RFX:    rfx_r    <= cfg_data[dpbp_pkg::RECIP_W-1:0];
        dpbp_pkg::REG_RFY:    rfy_r    <= cfg_data[dpbp_pkg::RECIP_W-1:0];
        dpbp_pkg::REG_THRESH: thresh_r <= cfg_data[dpbp_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cam.cx  = cx_r;
  assign cam.cy  = cy_r;
  assign cam.rfx = rfx_r;
  assign cam.rfy = rfy_r;

  // The front tracks the raster position and computes the pixel index and the
  // below-threshold flag; masked pixels advance the counters but are never queued.
  dpbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_depth_value    (in_depth_value),
    .in_pixel_selected (in_pixel_selected),
    .image_width       (width_r),
    .image_height      (height_r),
    .depth_threshold   (thresh_r),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_item            (q_item)
  );

  dpbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .stat       (q_stat)
  );

  // The back forms |pos*16 - center| * recip, then times depth, then rounds the
  // 28-fraction-bit product to 8 fraction bits and saturates to 32 bits signed.
  dpbp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_item         (head_item),
    .pop               (q_pop),
    .cam               (cam),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_point_z       (out_point_z),
    .out_point_invalid (out_point_invalid),
    .out_pixel_index   (out_pixel_index)
  );

`ifndef SYNTH
  // The queue never holds more entries than it has.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= dpbp_pkg::QCNT_W'(dpbp_pkg::QDEPTH))
    else $error("queue count beyond depth");

  // An invalid point carries zero coordinates and zero depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_invalid |->
      out_point_x == '0 && out_point_y == '0 && out_point_z == '0)
    else $error("invalid point with nonzero coordinates");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // The front only stalls when the queue is really full.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_stat.count == dpbp_pkg::QCNT_W'(dpbp_pkg::QDEPTH))
    else $error("input stalled with queue space left");
`endif

endmodule

// ===== rtl/dpbp_front.sv =====
// Front end: accepts pixels, tracks raster position, drops masked pixels and classifies depth.
// Depends on dpbp_pkg.
module dpbp_front #(
  parameter int MAX_WIDTH  = dpbp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dpbp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dpbp_pkg::DEPTH_W-1:0] in_depth_value,
  input  logic                         in_pixel_selected,
  input  logic [dpbp_pkg::DIM_W-1:0]   image_width,
  input  logic [dpbp_pkg::DIM_W-1:0]   image_height,
  input  logic [dpbp_pkg::DEPTH_W-1:0] depth_threshold,
  input  dpbp_pkg::qstat_t             q_stat,
  output logic                         q_push,
  output dpbp_pkg::item_t              q_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int LW = dpbp_pkg::DIM_W + 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [dpbp_pkg::DIM_W-1:0] w_eff, h_eff;
  logic accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept & in_pixel_selected;

  // Zero reads as one, values above the parameter are clamped to it.
  always_comb begin
    if (image_width == '0) begin
      w_eff = dpbp_pkg::DIM_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = dpbp_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = dpbp_pkg::DIM_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = dpbp_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (LW'(col_r) + LW'(1) >= LW'(w_eff)) begin
        col_nxt = '0;
        if (LW'(row_r) + LW'(1) >= LW'(h_eff)) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    q_item.depth   = in_depth_value;
    q_item.col     = dpbp_pkg::POS_W'(col_r);
    q_item.row     = dpbp_pkg::POS_W'(row_r);
    q_item.invalid = in_depth_value < depth_threshold;
    q_item.idx     = dpbp_pkg::IDX_W'(24'(row_r) * 24'(w_eff) + 24'(col_r));
  end

endmodule

// ===== rtl/dpbp_queue.sv =====
// Four-entry queue that decouples the front end from the projection pipeline.
// Depends on dpbp_pkg.
module dpbp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dpbp_pkg::item_t  push_item,
  input  logic             pop,
  output logic             head_valid,
  output dpbp_pkg::item_t  head_item,
  output dpbp_pkg::qstat_t stat
);

  dpbp_pkg::item_t mem_r [dpbp_pkg::QDEPTH];
  logic [dpbp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dpbp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dpbp_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign head_valid = count_r != '0;
  assign head_item  = mem_r[rd_ptr_r];
  assign stat.full  = count_r == dpbp_pkg::QCNT_W'(dpbp_pkg::QDEPTH);
  assign stat.count = count_r;

  assign do_push = push & ~stat.full;
  assign do_pop  = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + dpbp_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + dpbp_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + dpbp_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - dpbp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/dpbp_back.sv =====
// Projection pipeline: offset and first product, depth product, then rounding and saturation.
// Depends on dpbp_pkg.
module dpbp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  dpbp_pkg::item_t              head_item,
  output logic                         pop,
  input  dpbp_pkg::cam_cfg_t           cam,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dpbp_pkg::COORD_W-1:0] out_point_x,
  output logic [dpbp_pkg::COORD_W-1:0] out_point_y,
  output logic [dpbp_pkg::DEPTH_W-1:0] out_point_z,
  output logic                         out_point_invalid,
  output logic [dpbp_pkg::IDX_W-1:0]   out_pixel_index
);

  // Round to nearest with ties away from zero on the magnitude, then apply sign and saturate.
  function automatic logic [dpbp_pkg::COORD_W-1:0] round_sat(
    input logic [dpbp_pkg::PROD_W-1:0] prod,
    input logic                        neg
  );
    logic [dpbp_pkg::PROD_W:0]                sum;
    logic [dpbp_pkg::PROD_W-dpbp_pkg::RND_SH:0] r;
    logic [dpbp_pkg::COORD_W-1:0]             res;
    sum = {1'b0, prod} + ((dpbp_pkg::PROD_W + 1)'(1) << (dpbp_pkg::RND_SH - 1));
    r   = sum[dpbp_pkg::PROD_W:dpbp_pkg::RND_SH];
    if (neg) begin
      if (r > 37'h0_8000_0000) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'h0 - r[dpbp_pkg::COORD_W-1:0];
      end
    end else if (r > 37'h0_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else begin
      res = r[dpbp_pkg::COORD_W-1:0];
    end
    return res;
  endfunction

  logic adv1, adv2, adv3;
  logic v1_r, v2_r, v3_r;

  // Stage 1 datapath
  logic [dpbp_pkg::MAG_W-1:0] p16x, p16y, magx, magy;
  logic negx, negy;
  logic [dpbp_pkg::PART_W-1:0] px_r, py_r;
  logic negx1_r, negy1_r, inv1_r;
  logic [dpbp_pkg::DEPTH_W-1:0] depth1_r;
  logic [dpbp_pkg::IDX_W-1:0]   idx1_r;

  // Stage 2
  logic [dpbp_pkg::PROD_W-1:0] prx_r, pry_r;
  logic negx2_r, negy2_r, inv2_r;
  logic [dpbp_pkg::DEPTH_W-1:0] depth2_r;
  logic [dpbp_pkg::IDX_W-1:0]   idx2_r;

  // Output stage
  logic [dpbp_pkg::COORD_W-1:0] x3_r, y3_r;
  logic [dpbp_pkg::DEPTH_W-1:0] z3_r;
  logic inv3_r;
  logic [dpbp_pkg::IDX_W-1:0] idx3_r;

  assign adv3 = ~v3_r | ~out_stall;
  assign adv2 = ~v2_r | adv3;
  assign adv1 = ~v1_r | adv2;
  assign pop  = head_valid & adv1;

  always_comb begin
    p16x = {head_item.col, 4'b0000};
    p16y = {head_item.row, 4'b0000};
    negx = p16x < dpbp_pkg::MAG_W'(cam.cx);
    negy = p16y < dpbp_pkg::MAG_W'(cam.cy);
    magx = negx ? dpbp_pkg::MAG_W'(cam.cx) - p16x : p16x - dpbp_pkg::MAG_W'(cam.cx);
    magy = negy ? dpbp_pkg::MAG_W'(cam.cy) - p16y : p16y - dpbp_pkg::MAG_W'(cam.cy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= head_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      px_r     <= dpbp_pkg::PART_W'(magx) * dpbp_pkg::PART_W'(cam.rfx);
      py_r     <= dpbp_pkg::PART_W'(magy) * dpbp_pkg::PART_W'(cam.rfy);
      negx1_r  <= negx;
      negy1_r  <= negy;
      inv1_r   <= head_item.invalid;
      depth1_r <= head_item.depth;
      idx1_r   <= head_item.idx;
    end
    if (v1_r && adv2) begin
      prx_r    <= dpbp_pkg::PROD_W'(px_r) * dpbp_pkg::PROD_W'(depth1_r);
      pry_r    <= dpbp_pkg::PROD_W'(py_r) * dpbp_pkg::PROD_W'(depth1_r);
      negx2_r  <= negx1_r;
      negy2_r  <= negy1_r;
      inv2_r   <= inv1_r;
      depth2_r <= depth1_r;
      idx2_r   <= idx1_r;
    end
    if (v2_r && adv3) begin
      x3_r   <= inv2_r ? '0 : round_sat(prx_r, negx2_r);
      y3_r   <= inv2_r ? '0 : round_sat(pry_r, negy2_r);
      z3_r   <= inv2_r ? '0 : depth2_r;
      inv3_r <= inv2_r;
      idx3_r <= idx2_r;
    end
  end

  assign out_valid         = v3_r;
  assign out_point_x       = x3_r;
  assign out_point_y       = y3_r;
  assign out_point_z       = z3_r;
  assign out_point_invalid = inv3_r;
  assign out_pixel_index   = idx3_r;

endmodule
